### src/i2cm_pkg.sv
// Shared types and constants for the I2C register access master.
// Holds the tick item, result beat, configuration set and sequencer phase codes.
// No dependencies.
package i2cm_pkg;

	// Configuration register indexes and their reset values.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_DEV_ADDR    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT = 2'd2;

	localparam logic [6:0] DEV_ADDR_RST    = 7'd104;
	localparam logic [7:0] HALF_PERIOD_RST = 8'd2;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	// Which byte of the transaction is in flight.
	localparam logic [1:0] STEP_DEV   = 2'd0;
	localparam logic [1:0] STEP_REG   = 2'd1;
	localparam logic [1:0] STEP_LAST  = 2'd2;
	localparam logic [1:0] STEP_ABORT = 2'd3;

	typedef struct packed {
		logic [6:0] dev_addr;
		logic [7:0] half_period;
		logic [7:0] ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic       cmd_valid;
		logic       mode;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       nack;
	} res_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_S0   = 4'd1,
		PH_S1   = 4'd2,
		PH_S2   = 4'd3,
		PH_BL   = 4'd4,
		PH_BH   = 4'd5,
		PH_AL   = 4'd6,
		PH_AH   = 4'd7,
		PH_RL   = 4'd8,
		PH_RH   = 4'd9,
		PH_NL   = 4'd10,
		PH_NH   = 4'd11,
		PH_P0   = 4'd12,
		PH_P1   = 4'd13,
		PH_P2   = 4'd14
	} phase_t;

endpackage

### src/i2cm_fifo.sv
// Two-entry queue used on both sides of the sequencer.
// Generic in payload width; no package dependency.
module i2cm_fifo #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int unsigned DEPTH = 2;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == 2'(DEPTH));
	assign empty   = (count_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### src/i2cm_seq.sv
// Bus sequencer: advances the I2C phase machine by one tick per beat taken
// from the input queue and produces one result beat. Uses i2cm_pkg.
module i2cm_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  i2cm_pkg::cfg_t  cfg,
	input  logic          in_valid,
	input  i2cm_pkg::tick_t item,
	input  logic          out_space,
	output logic          fire,
	output i2cm_pkg::res_t  res
);
	import i2cm_pkg::*;

	phase_t     phase_q, phase_d;
	logic [1:0] step_q, step_d;
	logic [3:0] bit_cnt_q, bit_cnt_d;
	logic [7:0] tick_q, tick_d;
	logic [7:0] polls_q, polls_d;
	logic [7:0] shift_q, shift_d;
	logic       mode_q, mode_d;
	logic [7:0] reg_q, reg_d;
	logic [7:0] data_q, data_d;

	logic [7:0] half;
	logic [7:0] limit;
	logic       seg_end;
	logic [7:0] tick_seg;
	logic [3:0] bit_inc;
	logic [8:0] polls_sum;

	function automatic logic [7:0] byte_for(input logic [1:0] step, input logic is_read,
		input logic [6:0] dev, input logic [7:0] reg_byte, input logic [7:0] data_byte);
		logic [7:0] result;
		if (step == STEP_DEV) begin
			result = {dev, 1'b0};
		end else if (step == STEP_REG) begin
			result = reg_byte;
		end else if (is_read) begin
			result = {dev, 1'b1};
		end else begin
			result = data_byte;
		end
		return result;
	endfunction

	assign fire = in_valid && out_space;

	// A zero half period or timeout behaves as one.
	assign half     = (cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period;
	assign limit    = (cfg.ack_timeout == 8'd0) ? 8'd1 : cfg.ack_timeout;
	assign seg_end  = ({1'b0, tick_q} + 9'd1) >= {1'b0, half};
	assign tick_seg = seg_end ? 8'd0 : tick_q + 8'd1;
	assign bit_inc  = bit_cnt_q + 4'd1;
	assign polls_sum = {1'b0, polls_q} + 9'd1;

	// Line levels and status for the current tick.
	always_comb begin
		res           = '0;
		res.scl       = 1'b1;
		res.sda_out   = 1'b1;
		res.busy_res  = (phase_q != PH_IDLE) && (phase_q <= PH_P2);
		unique case (phase_q)
			PH_S0, PH_AL, PH_RL, PH_NL: begin
				res.scl = 1'b0;
			end
			PH_S2, PH_P1: begin
				res.sda_out = 1'b0;
			end
			PH_BL: begin
				res.scl     = 1'b0;
				res.sda_out = shift_q[7];
			end
			PH_BH: begin
				res.sda_out = shift_q[7];
			end
			PH_P0: begin
				res.scl     = 1'b0;
				res.sda_out = 1'b0;
			end
			PH_P2: begin
				if (seg_end) begin
					res.done_res  = 1'b1;
					res.nack      = (step_q == STEP_ABORT);
					res.read_data = (mode_q && step_q != STEP_ABORT) ? shift_q : 8'd0;
				end
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		phase_d   = phase_q;
		step_d    = step_q;
		bit_cnt_d = bit_cnt_q;
		tick_d    = tick_q;
		polls_d   = polls_q;
		shift_d   = shift_q;
		mode_d    = mode_q;
		reg_d     = reg_q;
		data_d    = data_q;
		if (fire) begin
			unique case (phase_q)
				PH_S0, PH_S1, PH_BL, PH_AL, PH_RL, PH_NL, PH_NH, PH_P0, PH_P1: begin
					tick_d = tick_seg;
					if (seg_end) begin
						unique case (phase_q)
							PH_S0:   phase_d = PH_S1;
							PH_S1:   phase_d = PH_S2;
							PH_BL:   phase_d = PH_BH;
							PH_AL:   phase_d = PH_AH;
							PH_RL:   phase_d = PH_RH;
							PH_NL:   phase_d = PH_NH;
							PH_NH:   phase_d = PH_P0;
							PH_P0:   phase_d = PH_P1;
							default: phase_d = PH_P2;
						endcase
					end
				end
				PH_S2: begin
					tick_d = tick_seg;
					if (seg_end) begin
						shift_d   = byte_for(step_q, mode_q, cfg.dev_addr, reg_q, data_q);
						bit_cnt_d = 4'd0;
						phase_d   = PH_BL;
					end
				end
				PH_BH: begin
					tick_d = tick_seg;
					if (seg_end) begin
						shift_d   = {shift_q[6:0], 1'b0};
						bit_cnt_d = bit_inc;
						if (bit_inc[3]) begin
							polls_d = 8'd0;
							phase_d = PH_AL;
						end else begin
							phase_d = PH_BL;
						end
					end
				end
				PH_AH: begin
					tick_d = 8'd0;
					if (!item.sda_in) begin
						// Acknowledge seen: move on to the next byte or phase.
						if (step_q == STEP_DEV) begin
							step_d    = STEP_REG;
							shift_d   = byte_for(STEP_REG, mode_q, cfg.dev_addr, reg_q, data_q);
							bit_cnt_d = 4'd0;
							phase_d   = PH_BL;
						end else if (step_q == STEP_REG) begin
							step_d = STEP_LAST;
							if (mode_q) begin
								phase_d = PH_S0;
							end else begin
								shift_d   = byte_for(STEP_LAST, mode_q, cfg.dev_addr, reg_q,
									data_q);
								bit_cnt_d = 4'd0;
								phase_d   = PH_BL;
							end
						end else if (mode_q) begin
							shift_d   = 8'd0;
							bit_cnt_d = 4'd0;
							phase_d   = PH_RL;
						end else begin
							phase_d = PH_P0;
						end
					end else begin
						polls_d = polls_sum[7:0];
						if (polls_sum >= {1'b0, limit}) begin
							step_d  = STEP_ABORT;
							phase_d = PH_P0;
						end
					end
				end
				PH_RH: begin
					// The read bit is sampled on the first tick of SCL high.
					if (tick_q == 8'd0) begin
						shift_d = {shift_q[6:0], item.sda_in};
					end
					tick_d = tick_seg;
					if (seg_end) begin
						bit_cnt_d = bit_inc;
						phase_d   = bit_inc[3] ? PH_NL : PH_RL;
					end
				end
				PH_P2: begin
					tick_d = tick_seg;
					if (seg_end) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					if (item.cmd_valid) begin
						mode_d    = item.mode;
						reg_d     = item.reg_addr;
						data_d    = item.write_data;
						step_d    = STEP_DEV;
						bit_cnt_d = 4'd0;
						tick_d    = 8'd0;
						polls_d   = 8'd0;
						shift_d   = 8'd0;
						phase_d   = PH_S0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			step_q    <= STEP_DEV;
			bit_cnt_q <= 4'd0;
			tick_q    <= 8'd0;
			polls_q   <= 8'd0;
			shift_q   <= 8'd0;
			mode_q    <= 1'b0;
			reg_q     <= 8'd0;
			data_q    <= 8'd0;
		end else begin
			phase_q   <= phase_d;
			step_q    <= step_d;
			bit_cnt_q <= bit_cnt_d;
			tick_q    <= tick_d;
			polls_q   <= polls_d;
			shift_q   <= shift_d;
			mode_q    <= mode_d;
			reg_q     <= reg_d;
			data_q    <= data_d;
		end
	end

endmodule

### src/i2c_master_register_access_top.sv
// Top level of the I2C register access master: input tick queue, bus
// sequencer, result queue and configuration registers. Uses i2cm_pkg,
// i2cm_fifo and i2cm_seq.
//
//   Channel   Handshake          Payload
//   --------  -----------------  ------------------------------------------------
//   tick in   push / full        cmd_valid, mode, reg_addr, write_data, sda_in
//   result    empty / pop        scl, sda_out, busy_res, done_res, read_data, nack
//   config    cfg_we             cfg_index, cfg_wdata
//
// Every tick beat yields exactly one result beat, and the block takes one beat per
// clock cycle unless a full queue holds the flow. A pushed beat is registered in the
// input queue, the sequencer steps on it from the head of that queue, and its result
// beat is registered in the result queue, from where it can be popped.
// Reset empties both queues, idles the sequencer and loads the register defaults.
// A stalled consumer fills the result queue, then the input queue, and full rises.
module i2c_master_register_access_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              cmd_valid,
	input  logic                              mode,
	input  logic [7:0]                        reg_addr,
	input  logic [7:0]                        write_data,
	input  logic                              sda_in,
	output logic                              empty,
	input  logic                              pop,
	output logic                              scl,
	output logic                              sda_out,
	output logic                              busy_res,
	output logic                              done_res,
	output logic [7:0]                        read_data,
	output logic                              nack,
	input  logic                              cfg_we,
	input  logic [i2cm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [i2cm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import i2cm_pkg::*;

	cfg_t  cfg_q;
	tick_t tick_in;
	tick_t tick_head;
	res_t  res_new;
	res_t  res_head;
	logic  tick_empty;
	logic  res_full;
	logic  seq_fire;

	// Configuration registers. The user must write them only while no beat is in
	// flight (not enforced by the block). The sequencer reads them directly, so a
	// change takes effect at once, even mid-transaction. An index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr    <= DEV_ADDR_RST;
			cfg_q.half_period <= HALF_PERIOD_RST;
			cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEV_ADDR:    cfg_q.dev_addr    <= cfg_wdata[6:0];
				CFG_HALF_PERIOD: cfg_q.half_period <= cfg_wdata;
				CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign tick_in.cmd_valid  = cmd_valid;
	assign tick_in.mode       = mode;
	assign tick_in.reg_addr   = reg_addr;
	assign tick_in.write_data = write_data;
	assign tick_in.sda_in     = sda_in;

	// Front: tick beats queue here until the sequencer takes them.
	i2cm_fifo #(
		.WIDTH($bits(tick_t))
	) u_tick_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (tick_in),
		.rd_en   (seq_fire),
		.rd_data (tick_head),
		.full    (full),
		.empty   (tick_empty)
	);

	// Back: one phase-machine step per beat.
	i2cm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (!tick_empty),
		.item      (tick_head),
		.out_space (!res_full),
		.fire      (seq_fire),
		.res       (res_new)
	);

	// Result beats wait here for the consumer.
	i2cm_fifo #(
		.WIDTH($bits(res_t))
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (seq_fire),
		.wr_data (res_new),
		.rd_en   (pop),
		.rd_data (res_head),
		.full    (res_full),
		.empty   (empty)
	);

	assign scl       = res_head.scl;
	assign sda_out   = res_head.sda_out;
	assign busy_res  = res_head.busy_res;
	assign done_res  = res_head.done_res;
	assign read_data = res_head.read_data;
	assign nack      = res_head.nack;

endmodule

### src/i2cm_checker.sv
// Port-level checks for the I2C register access master, bound to the top level.
// Depends only on the top level's ports.
module i2cm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       empty,
	input logic       pop,
	input logic       scl,
	input logic       sda_out,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_data,
	input logic       nack
);

	// A finishing beat always belongs to a running transaction.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && done_res) |-> busy_res)
		else $error("done beat without busy");

	// A timed-out acknowledge is reported only on the finishing beat, with no data.
	a_nack_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && nack) |-> (done_res && read_data == 8'd0))
		else $error("nack outside a done beat or with data");

	// Read data is zero except on the finishing beat.
	a_data_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !done_res) |-> (read_data == 8'd0))
		else $error("read data outside a done beat");

	// An idle bus leaves both lines released.
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !busy_res) |-> (scl && sda_out))
		else $error("line driven while idle");

	// A waiting result beat stays until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(read_data) && $stable(scl)
			&& $stable(sda_out)))
		else $error("result beat changed while stalled");

endmodule

bind i2c_master_register_access_top i2cm_checker u_i2cm_checker (.*);
